// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Clock clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define TSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When ante holds, cons must hold on the following edge.
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tsr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants for the fixed-point square root block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VALUE_W       = 32;
  localparam int ROOT_W        = 24;
  localparam int ITER_W        = 8;
  localparam int SQ_W          = 2 * VALUE_W;
  localparam int DEN_W         = VALUE_W + 1;
  localparam int CFG_IDX_W     = 1;

  localparam logic [VALUE_W-1:0] TOL_RESET  = VALUE_W'(197);
  localparam logic [ITER_W-1:0]  ITER_RESET = ITER_W'(64);
  localparam logic [ROOT_W-1:0]  ROOT_MAX   = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS = 1'd1;

  // request method codes
  localparam logic METHOD_BISECT = 1'b0;
  localparam logic METHOD_NEWTON = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N_SQ,
    ST_N_CHK,
    ST_N_DIV,
    ST_B_SQB,
    ST_B_CHKB,
    ST_B_MID,
    ST_B_SQ,
    ST_B_CHK,
    ST_FIN
  } tsr_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/tsr_sqr.sv -----
// ----------------------------------------------------------------------------
// tsr_sqr
// Shared squaring unit: exact 32x32 square, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsr_sqr (
  input  logic                        clk_i,
  input  logic [tsr_pkg::VALUE_W-1:0] x_i,
  output logic [tsr_pkg::SQ_W-1:0]    prod_o
);

  logic [tsr_pkg::SQ_W-1:0] prod_d, prod_q;

  assign prod_d = tsr_pkg::SQ_W'(x_i) * tsr_pkg::SQ_W'(x_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/core/tsr_div.sv -----
// ----------------------------------------------------------------------------
// tsr_div
// Radix-2 restoring divider, 64 / 33 bits, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsr_pkg::SQ_W-1:0]    num_i,
  input  logic [tsr_pkg::DEN_W-1:0]   den_i,
  output tsr_pkg::div_stat_t          stat_o,
  output logic [tsr_pkg::VALUE_W-1:0] quot_o
);

  localparam int QW    = tsr_pkg::VALUE_W;
  localparam int DW    = tsr_pkg::DEN_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    den_q, den_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [QW-1:0]    low_q, low_d;
  logic [QW-1:0]    quo_q, quo_d;

  logic [DW:0]      trial;
  logic [DW:0]      trial_sub;
  logic             ge;

  assign trial     = {rem_q, low_q[QW-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      // quotient would not fit in 32 bits when the high half already reaches den
      ovf_d  = {1'b0, num_i[tsr_pkg::SQ_W-1:QW]} >= den_i;
      cnt_d  = '0;
      den_d  = den_i;
      rem_d  = {1'b0, num_i[tsr_pkg::SQ_W-1:QW]};
      low_d  = num_i[QW-1:0];
    end else if (busy_q) begin
      if (ovf_q) begin
        quo_d  = '1;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        rem_d = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
        quo_d = {quo_q[QW-2:0], ge};
        low_d = {low_q[QW-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    cnt_q <= cnt_d;
    den_q <= den_d;
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

// ----- rtl/core/tolerance_square_root.sv -----
// ----------------------------------------------------------------------------
// tolerance_square_root
// Bisection: the upper end point is squared and checked, then each halving runs
// the midpoint, square and check states. Newton: each update squares, checks and
// runs the 32-step serial divider. Throughput: one word at a time; the next word
// is taken once the result is staged in the output register. Reset is
// asynchronous, active low, and restores tolerance 197 and max_iterations 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tolerance_square_root #(
  parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsr_pkg::VALUE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [tsr_pkg::VALUE_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tsr_pkg::ROOT_W-1:0]    root_o,
  output logic                          converged_o
);

  localparam int VW = tsr_pkg::VALUE_W;
  localparam int SW = tsr_pkg::SQ_W;
  localparam int IW = tsr_pkg::ITER_W;
  localparam int RW = tsr_pkg::ROOT_W;
  localparam logic [VW-1:0] ONE_FIX = VW'(1) << FRAC_BITS;

  tsr_pkg::tsr_state_e state_q, state_d;

  logic [VW-1:0] tol_q, tol_d;
  logic [IW-1:0] iter_q, iter_d;
  logic          out_valid_q, out_valid_d;

  logic [VW-1:0] x_q, x_d;
  logic [VW-1:0] a_q, a_d;
  logic [VW-1:0] b_q, b_d;
  logic [VW-1:0] v_q, v_d;
  logic [IW-1:0] n_q, n_d;
  logic          ok_q, ok_d;
  logic [RW-1:0] root_q, root_d;
  logic          conv_q, conv_d;

  logic [SW-1:0]            prod;
  logic [SW-1:0]            vs, es, diff;
  logic [SW:0]              sum;
  logic [SW-1:0]            num;
  logic                     s_ge, tol_ok, at_cap, at_cap_inc, exact;
  logic [IW-1:0]            cap, n_inc;
  logic [VW:0]              mid_sum;
  logic [VW-1:0]            b_init;
  logic                     div_start, load_out;
  tsr_pkg::div_stat_t       div_stat;
  logic [VW-1:0]            quot;
  logic                     in_bisect, in_divide;

  tsr_sqr u_sqr (
    .clk_i  (clk_i),
    .x_i    (x_q),
    .prod_o (prod)
  );

  tsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   ({x_q, 1'b0}),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  // shared datapath terms
  assign vs         = SW'(v_q) << FRAC_BITS;
  assign es         = SW'(tol_q) << FRAC_BITS;
  assign s_ge       = prod >= vs;
  assign diff       = s_ge ? (prod - vs) : (vs - prod);
  assign tol_ok     = diff < es;
  assign exact      = prod == vs;
  assign sum        = {1'b0, prod} + {1'b0, vs};
  assign num        = sum[SW] ? '1 : sum[SW-1:0];
  assign cap        = (iter_q == '0) ? IW'(1) : iter_q;
  assign n_inc      = n_q + IW'(1);
  assign at_cap     = n_q >= cap;
  assign at_cap_inc = n_inc >= cap;
  assign mid_sum    = {1'b0, a_q} + {1'b0, b_q};
  assign b_init     = (value_i > ONE_FIX) ? value_i : ONE_FIX;
  assign load_out   = (state_q == tsr_pkg::ST_FIN) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == tsr_pkg::METHOD_NEWTON) begin
            state_d = tsr_pkg::ST_N_SQ;
          end else if (value_i == '0) begin
            state_d = tsr_pkg::ST_FIN;
          end else begin
            state_d = tsr_pkg::ST_B_SQB;
          end
        end
      end
      tsr_pkg::ST_N_SQ:  state_d = tsr_pkg::ST_N_CHK;
      tsr_pkg::ST_N_CHK: begin
        if (tol_ok || at_cap) begin
          state_d = tsr_pkg::ST_FIN;
        end else if (x_q == '0) begin
          state_d = tsr_pkg::ST_N_SQ;
        end else begin
          state_d = tsr_pkg::ST_N_DIV;
        end
      end
      tsr_pkg::ST_N_DIV: begin
        if (div_stat.done) state_d = tsr_pkg::ST_N_SQ;
      end
      tsr_pkg::ST_B_SQB:  state_d = tsr_pkg::ST_B_CHKB;
      tsr_pkg::ST_B_CHKB: state_d = exact ? tsr_pkg::ST_FIN : tsr_pkg::ST_B_MID;
      tsr_pkg::ST_B_MID:  state_d = tsr_pkg::ST_B_SQ;
      tsr_pkg::ST_B_SQ:   state_d = tsr_pkg::ST_B_CHK;
      tsr_pkg::ST_B_CHK: begin
        state_d = (tol_ok || at_cap_inc) ? tsr_pkg::ST_FIN : tsr_pkg::ST_B_MID;
      end
      tsr_pkg::ST_FIN: begin
        if (load_out) state_d = tsr_pkg::ST_IDLE;
      end
      default: state_d = tsr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    x_d       = x_q;
    a_d       = a_q;
    b_d       = b_q;
    v_d       = v_q;
    n_d       = n_q;
    ok_d      = ok_q;
    div_start = 1'b0;
    case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          v_d  = value_i;
          a_d  = '0;
          n_d  = '0;
          ok_d = 1'b0;
          if (req_type_i == tsr_pkg::METHOD_NEWTON) begin
            x_d = ONE_FIX;
          end else if (value_i == '0) begin
            x_d  = '0;
            ok_d = 1'b1;
          end else begin
            x_d = b_init;
            b_d = b_init;
          end
        end
      end
      tsr_pkg::ST_N_CHK: begin
        if (tol_ok) begin
          ok_d = 1'b1;
        end else if (!at_cap) begin
          if (x_q == '0) begin
            n_d = n_inc;       // zero estimate stays put
          end else begin
            div_start = 1'b1;
          end
        end
      end
      tsr_pkg::ST_N_DIV: begin
        if (div_stat.done) begin
          x_d = quot;
          n_d = n_inc;
        end
      end
      tsr_pkg::ST_B_CHKB: begin
        if (exact) ok_d = 1'b1;
      end
      tsr_pkg::ST_B_MID: begin
        x_d = mid_sum[VW:1];
      end
      tsr_pkg::ST_B_CHK: begin
        if (s_ge) begin
          b_d = x_q;
        end else begin
          a_d = x_q;
        end
        n_d = n_inc;
        if (tol_ok) ok_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    root_d      = root_q;
    conv_d      = conv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      root_d      = (x_q > VW'(tsr_pkg::ROOT_MAX)) ? tsr_pkg::ROOT_MAX : x_q[RW-1:0];
      conv_d      = ok_q;
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    tol_d  = tol_q;
    iter_d = iter_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tsr_pkg::REG_TOLERANCE:      tol_d  = cfg_data_i;
        tsr_pkg::REG_MAX_ITERATIONS: iter_d = cfg_data_i[IW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsr_pkg::ST_IDLE;
      tol_q       <= tsr_pkg::TOL_RESET;
      iter_q      <= tsr_pkg::ITER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tol_q       <= tol_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    a_q    <= a_d;
    b_q    <= b_d;
    v_q    <= v_d;
    n_q    <= n_d;
    ok_q   <= ok_d;
    root_q <= root_d;
    conv_q <= conv_d;
  end

  assign in_ready_o  = state_q == tsr_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;
  assign converged_o = conv_q;

  // bisection loop states, where the interval bounds are live
  assign in_bisect = (state_q == tsr_pkg::ST_B_MID) || (state_q == tsr_pkg::ST_B_SQ) ||
                     (state_q == tsr_pkg::ST_B_CHK);
  assign in_divide = state_q == tsr_pkg::ST_N_DIV;

  `TSR_ASSERT(a_iter_cap, in_ready_o || (n_q <= cap), "iteration count past cap")
  `TSR_ASSERT(a_bisect_order, !in_bisect || (a_q <= b_q), "bisection interval inverted")
  `TSR_ASSERT(a_div_owner, !div_stat.busy || in_divide, "divider busy outside Newton divide")
  `TSR_ASSERT_NEXT(a_result_load, load_out, out_valid_o && in_ready_o, "result not staged")

endmodule

// ----- verif/tolerance_square_root_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerance_square_root_check
// Watches the configuration port and both word channels of the square root
// block. It keeps its own copy of the registers, computes the expected root
// word when a request is accepted, and compares each result word in order.
// ----------------------------------------------------------------------------
module tolerance_square_root_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsr_pkg::VALUE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          req_type_i,
  input  logic [tsr_pkg::VALUE_W-1:0]   value_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [tsr_pkg::ROOT_W-1:0]    root_i,
  input  logic                          converged_i,
  output int unsigned                   err_cnt_o,
  output int unsigned                   open_cnt_o
);
  import tsr_pkg::*;

  localparam int          FRAC  = FRAC_BITS_DEF;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              converged;
  } root_word_t;

  logic [VALUE_W-1:0] tol_q    = TOL_RESET;
  logic [ITER_W-1:0]  iter_cap = ITER_RESET;
  root_word_t         roots_due[$];
  int unsigned        miss_cnt = 0;
  int unsigned        open_cnt = 0;

  assign err_cnt_o  = miss_cnt;
  assign open_cnt_o = open_cnt;

  // squares carry 2*FRAC fraction bits, so value and tolerance are scaled up to match
  function automatic bit close_enough(logic [63:0] x, logic [63:0] vs, logic [63:0] es);
    logic [63:0] sq;
    sq = x * x;
    return ((sq >= vs) ? sq - vs : vs - sq) < es;
  endfunction

  function automatic logic [63:0] newton_update(logic [63:0] x, logic [63:0] vs);
    logic [64:0] sum;
    logic [63:0] num;
    if (x == 0) return 64'd0;
    sum = {1'b0, x * x} + {1'b0, vs};
    num = sum[64] ? '1 : sum[63:0];
    num = num / (x << 1);
    return (num > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : num;
  endfunction

  function automatic root_word_t predict_root(logic method, logic [VALUE_W-1:0] v,
                                              logic [VALUE_W-1:0] tol,
                                              logic [ITER_W-1:0] iters);
    logic [63:0] vs, es, x, lo, hi;
    int unsigned cap, n;
    bit          ok, done;
    root_word_t  w;
    vs   = 64'(v) << FRAC;
    es   = 64'(tol) << FRAC;
    cap  = (iters == 0) ? 1 : iters;
    x    = '0;
    ok   = 1'b0;
    done = 1'b0;
    n    = 0;
    if (method == METHOD_NEWTON) begin
      x = ONE_Q;
      while (!done) begin
        if (close_enough(x, vs, es)) begin
          ok   = 1'b1;
          done = 1'b1;
        end else if (n >= cap) begin
          done = 1'b1;
        end else begin
          x = newton_update(x, vs);
          n++;
        end
      end
    end else begin
      lo = '0;
      hi = (64'(v) > ONE_Q) ? 64'(v) : ONE_Q;
      if (v == 0) begin
        ok = 1'b1;
      end else if (hi * hi == vs) begin
        // upper end point is already the exact root
        x  = hi;
        ok = 1'b1;
      end else begin
        while (!done && n < cap) begin
          x = (lo + hi) >> 1;
          if (x * x < vs) lo = x;
          else hi = x;
          if (close_enough(x, vs, es)) begin
            ok   = 1'b1;
            done = 1'b1;
          end
          n++;
        end
      end
    end
    w.root      = (x > 64'(ROOT_MAX)) ? ROOT_MAX : x[ROOT_W-1:0];
    w.converged = ok;
    return w;
  endfunction

  task automatic report_miss(string what, longint unsigned got, longint unsigned want);
    miss_cnt++;
    $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    root_word_t want;
    if (!rst_ni) begin
      tol_q    = TOL_RESET;
      iter_cap = ITER_RESET;
      roots_due.delete();
      open_cnt = 0;
    end else begin
      // a result word can never belong to a request taken on the same edge
      if (out_valid_i && out_ready_i) begin
        if (roots_due.size() == 0) begin
          report_miss("result word with nothing pending, root", root_i, 0);
        end else begin
          want = roots_due.pop_front();
          open_cnt--;
          if (root_i !== want.root) report_miss("root", root_i, want.root);
          if (converged_i !== want.converged)
            report_miss("converged", converged_i, want.converged);
        end
      end
      if (in_valid_i && in_ready_i) begin
        roots_due.push_back(predict_root(req_type_i, value_i, tol_q, iter_cap));
        open_cnt++;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TOLERANCE) tol_q = cfg_data_i;
        else if (cfg_idx_i == REG_MAX_ITERATIONS) iter_cap = cfg_data_i[ITER_W-1:0];
      end
    end
  end

endmodule

// ----- verif/tolerance_square_root_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tolerance_square_root_tb
// Drives request words into the fixed-point square root block through several
// tolerance and iteration-cap settings, with random gaps on both channels and
// one long output stall. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tolerance_square_root_tb;
  import tsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 600;
  localparam int TAIL_CYCLES    = 50;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = REG_TOLERANCE;
  logic [VALUE_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 req_type  = METHOD_BISECT;
  logic [VALUE_W-1:0]   value     = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROOT_W-1:0]    root;
  logic                 converged;
  int unsigned          miss_cnt;
  int unsigned          open_cnt;
  int unsigned          stall_cycles = 0;
  bit                   send_burst   = 1'b0;
  bit                   recv_burst   = 1'b0;

  always #5 clk = ~clk;

  tolerance_square_root uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .root_o      (root),
    .converged_o (converged)
  );

  tolerance_square_root_check chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .req_type_i  (req_type),
    .value_i     (value),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .root_i      (root),
    .converged_i (converged),
    .err_cnt_o   (miss_cnt),
    .open_cnt_o  (open_cnt)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", stall_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, bursts with none, and one long hold to back up the block
  initial begin : receiver
    int unsigned gap, taken;
    taken = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 13);
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      @(negedge clk);
    end
  end

  task automatic send_word(logic method, logic [VALUE_W-1:0] v);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= method;
    value    <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // block handles one word at a time, so an empty result queue means it is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (open_cnt != 0) @(negedge clk);
  endtask

  // mostly small values so Newton runs converge; some full-range, exact squares, near 1.0
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] k;
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1, 2, 3: return $urandom_range(0, 32'h000F_FFFF);
      4, 5:    return $urandom_range(0, 32'h00FF_FFFF);
      6: begin
        k = $urandom_range(0, 32'h0000_FFFF);
        return k * k;
      end
      7:       return 32'h0001_0000 - 32'h100 + $urandom_range(0, 32'h200);
      8:       return $urandom_range(0, 32'hFF) << 16;
      default: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 32'd1;
          2:       return 32'h0001_0000;
          3:       return '1;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_tolerance();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return $urandom_range(1, 500);
      2:       return $urandom_range(0, 32'h000F_FFFF);
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random(int unsigned count);
    repeat (count)
      send_word($urandom_range(0, 1) ? METHOD_NEWTON : METHOD_BISECT, pick_value());
  endtask

  initial begin : stimulus
    int unsigned ph;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: end points, initial guess already good, range extremes
    send_word(METHOD_BISECT, '0);
    send_word(METHOD_BISECT, 32'h0001_0000);
    send_word(METHOD_BISECT, '1);
    send_word(METHOD_BISECT, 32'h0000_8000);
    send_word(METHOD_BISECT, 32'h0004_0000);
    send_word(METHOD_NEWTON, '0);
    send_word(METHOD_NEWTON, 32'h0001_0000);
    send_word(METHOD_NEWTON, '1);
    send_word(METHOD_NEWTON, 32'h0002_0000);
    send_word(METHOD_NEWTON, 32'd1);
    run_random(250);
    settle();

    // zero tolerance is never met, so every request runs to the full cap
    set_reg(REG_TOLERANCE, '0);
    set_reg(REG_MAX_ITERATIONS, 32'hFF);
    send_word(METHOD_NEWTON, '0);  // estimate halves down to zero and sticks there
    send_word(METHOD_NEWTON, 32'h0001_0000);
    send_word(METHOD_BISECT, 32'h0002_0000);
    send_word(METHOD_BISECT, '1);
    send_word(METHOD_NEWTON, 32'h0002_0000);
    settle();

    // widest tolerance; cap of 1 written with junk in the upper bits
    set_reg(REG_TOLERANCE, '1);
    set_reg(REG_MAX_ITERATIONS, 32'hFFFF_FF01);
    send_word(METHOD_NEWTON, '1);
    run_random(250);
    settle();

    // cap of 0 behaves as 1; tight tolerance leaves huge first estimates that saturate
    set_reg(REG_TOLERANCE, 32'd1);
    set_reg(REG_MAX_ITERATIONS, '0);
    send_word(METHOD_NEWTON, '1);
    send_word(METHOD_BISECT, '1);
    send_word(METHOD_NEWTON, 32'h1234_5678);
    run_random(200);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      set_reg(REG_TOLERANCE, pick_tolerance());
      set_reg(REG_MAX_ITERATIONS, ($urandom() & 32'hFFFF_FF00) | $urandom_range(1, 20));
      run_random(150);
      settle();
    end

    set_reg(REG_TOLERANCE, TOL_RESET);
    set_reg(REG_MAX_ITERATIONS, VALUE_W'(ITER_RESET));
    run_random(100);
    settle();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (miss_cnt == 0 && open_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tsr_pkg.sv
rtl/core/tsr_sqr.sv
rtl/core/tsr_div.sv
rtl/core/tolerance_square_root.sv
verif/tolerance_square_root_check.sv
verif/tolerance_square_root_tb.sv
